>>> src/spi3m_pkg.sv
// Shared types and constants of the three-wire nine-bit serial master.
`default_nettype none
package spi3m_pkg;

  localparam int CMD_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 3;
  localparam int LINE_W     = 32;
  localparam int IDX_W      = 6;
  localparam int WORD_W     = BYTE_W + 1;

  localparam logic [CMD_W-1:0] CMD_WRITE_CMD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_PARAM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ        = 2'd2;

  localparam int DEFAULT_MAX_READ_BYTES = 4;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One frame as the back end needs it.
  typedef struct packed {
    logic [WORD_W-1:0] tx;          // flag bit followed by the byte, msb first
    logic              dummy;       // one released period before sampling
    logic [IDX_W-1:0]  last_index;  // index of the final period
    logic [LINE_W-1:0] line_bits;
  } desc_t;

endpackage
`default_nettype wire

>>> src/spi3m_if.sv
// Valid/ready channel interfaces for frame requests and serial periods.
`default_nettype none
interface spi3m_req_if;
  import spi3m_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [BYTE_W-1:0]  data_byte;
  logic [COUNT_W-1:0] read_count;
  logic [LINE_W-1:0]  line_bits;

  modport source (output valid, command, data_byte, read_count, line_bits, input ready);
  modport sink   (input valid, command, data_byte, read_count, line_bits, output ready);
endinterface

interface spi3m_rsp_if;
  import spi3m_pkg::*;
  logic              valid;
  logic              ready;
  logic              sdi_level;
  logic              sdi_driven;
  logic [IDX_W-1:0]  period_index;
  logic [LINE_W-1:0] read_data;
  logic              last;

  modport source (output valid, sdi_level, sdi_driven, period_index, read_data, last,
                  input ready);
  modport sink   (input valid, sdi_level, sdi_driven, period_index, read_data, last,
                  output ready);
endinterface
`default_nettype wire

>>> src/spi3m_front.sv
// Front end: accepts frame requests, drops unused codes, builds frame descriptors.
`default_nettype none
module spi3m_front
  import spi3m_pkg::*;
#(
  parameter int MAX_READ_BYTES = DEFAULT_MAX_READ_BYTES
) (
  spi3m_req_if.sink req,
  input  wire logic  q_full,
  output logic       push,
  output desc_t      desc
);

  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_READ_BYTES);

  logic               is_read;
  logic [COUNT_W-1:0] count;

  assign req.ready = !q_full;

  always_comb begin
    is_read = (req.command == CMD_READ);
    count   = '0;
    if (is_read) begin
      count = (req.read_count > MaxCount) ? MaxCount : req.read_count;
    end
    desc.tx         = {(req.command == CMD_WRITE_PARAM), req.data_byte};
    desc.dummy      = is_read && (count > COUNT_W'(1));
    desc.last_index = IDX_W'(BYTE_W) + IDX_W'(desc.dummy) + IDX_W'({count, 3'b000});
    desc.line_bits  = req.line_bits;
  end

  // Drop the unused command code: it makes no frame.
  assign push = req.valid && req.ready
                && (req.command == CMD_WRITE_CMD || req.command == CMD_WRITE_PARAM
                    || req.command == CMD_READ);

endmodule
`default_nettype wire

>>> src/spi3m_queue.sv
// Short descriptor queue between front and back end.
`default_nettype none
module spi3m_queue
  import spi3m_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  desc_t      din,
  output logic       full,
  output logic       valid,
  output desc_t      dout,
  input  wire logic  pop
);

  desc_t              entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full  = (count == Q_CNT_W'(Q_DEPTH));
  assign valid = (count != '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule
`default_nettype wire

>>> src/spi3m_back.sv
// Back end: plays a frame as serial periods into an output register, one per cycle unless stalled.
`default_nettype none
module spi3m_back
  import spi3m_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  desc_t      q_head,
  output logic       pop,
  spi3m_rsp_if.source rsp
);

  logic              busy;
  logic              busy_next;
  logic [WORD_W-1:0] tx;
  logic              dummy;
  logic [IDX_W-1:0]  last_index;
  logic [LINE_W-1:0] line;
  logic [LINE_W-1:0] rd;
  logic [LINE_W-1:0] rd_next;
  logic [IDX_W-1:0]  idx;

  logic              out_valid;
  logic              advance;
  logic              fin;
  logic              driving;
  logic              sampling;

  always_comb begin
    advance  = busy && (!out_valid || rsp.ready);
    fin      = (idx == last_index);
    driving  = (idx <= IDX_W'(BYTE_W));
    sampling = !driving && !(dummy && idx == IDX_W'(BYTE_W + 1));
    rd_next  = {rd[LINE_W-2:0], line[LINE_W-1]};
    // Load the next frame as soon as the current one emits its final period.
    pop       = q_valid && (!busy || (advance && fin));
    busy_next = pop ? 1'b1 : ((advance && fin) ? 1'b0 : busy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tx         <= q_head.tx;
      dummy      <= q_head.dummy;
      last_index <= q_head.last_index;
      line       <= q_head.line_bits;
      rd         <= '0;
      idx        <= '0;
    end else if (advance) begin
      tx  <= {tx[WORD_W-2:0], 1'b0};
      idx <= idx + 1'b1;
      if (sampling) begin
        line <= {line[LINE_W-2:0], 1'b0};
        rd   <= rd_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.sdi_level    <= driving ? tx[WORD_W-1] : 1'b0;
      rsp.sdi_driven   <= driving;
      rsp.period_index <= idx;
      rsp.read_data    <= (fin && sampling) ? rd_next : '0;
      rsp.last         <= fin;
    end
  end

  assign rsp.valid = out_valid;

endmodule
`default_nettype wire

>>> src/three_wire_nine_bit_spi_master.sv
// A taken request's frame passes the queue, the back end registers and the output register.
// Throughput: one serial period per cycle unless rsp.ready holds the output; a write frame
// has 9 periods, a read 9 + dummy + 8 per byte (up to 42), set by the back end's single period counter.
// Frames follow each other with no gap while the descriptor queue holds the next one.
// Synchronous reset empties the queue, stops the back end and drops the output beat.
`default_nettype none
module three_wire_nine_bit_spi_master
  import spi3m_pkg::*;
#(
  parameter int MAX_READ_BYTES = DEFAULT_MAX_READ_BYTES
) (
  input wire logic     clk,
  input wire logic     rst,
  spi3m_req_if.sink    req,
  spi3m_rsp_if.source  rsp
);

  logic  push;
  logic  q_full;
  logic  q_valid;
  logic  pop;
  desc_t desc;
  desc_t q_head;

  spi3m_front #(
    .MAX_READ_BYTES(MAX_READ_BYTES)
  ) u_front (
    .req    (req),
    .q_full (q_full),
    .push   (push),
    .desc   (desc)
  );

  spi3m_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (desc),
    .full  (q_full),
    .valid (q_valid),
    .dout  (q_head),
    .pop   (pop)
  );

  spi3m_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .rsp     (rsp)
  );

  a_read_data_only_on_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.last |-> rsp.read_data == '0)
    else $error("read data shown before the final period");

  a_driven_only_in_word: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.sdi_driven |-> rsp.period_index <= IDX_W'(BYTE_W))
    else $error("data line driven after the nine-bit word");

  a_flag_period_driven: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.period_index == '0 |-> rsp.sdi_driven && !rsp.last)
    else $error("flag period released or marked final");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("descriptor taken from an empty queue");

endmodule
`default_nettype wire
